// ----- sv/uvs_pkg.sv -----
`timescale 1ns / 1ps
package uvs_pkg;

	// Grid limits and field widths
	localparam int MAX_DIVISIONS = 1024;
	localparam int CNT_W         = 11;
	localparam int ADDR_W        = 4;

	// Register map, by word index
	localparam logic [1:0] REG_RADIUS  = 2'd0;
	localparam logic [1:0] REG_SECTORS = 2'd1;
	localparam logic [1:0] REG_STACKS  = 2'd2;

	// Divider: one integer bit, then 32 fraction bits, four per stage
	localparam int DIV_FRAC   = 32;
	localparam int DIV_BITS   = 4;
	localparam int DIV_STAGES = DIV_FRAC / DIV_BITS;
	localparam int DIV_LAT    = DIV_STAGES + 1;

	// CORDIC: 24 steps, two per stage, plus entry and exit registers
	localparam int CORDIC_STEPS     = 24;
	localparam int CORDIC_PER_STAGE = 2;
	localparam int CORDIC_STAGES    = CORDIC_STEPS / CORDIC_PER_STAGE;
	localparam int COR_LAT          = CORDIC_STAGES + 2;
	localparam logic signed [32:0] CORDIC_ONE = 33'sd652032874;

	// Arctangent of 2^-i in fractions of a full turn, 2^32 = one turn
	function automatic logic [31:0] atan_turn(input int i);
		logic [31:0] a;
		case (i)
			0:  a = 32'd536870912;
			1:  a = 32'd316933406;
			2:  a = 32'd167458907;
			3:  a = 32'd85004756;
			4:  a = 32'd42667331;
			5:  a = 32'd21354465;
			6:  a = 32'd10679838;
			7:  a = 32'd5340245;
			8:  a = 32'd2670163;
			9:  a = 32'd1335087;
			10: a = 32'd667544;
			11: a = 32'd333772;
			12: a = 32'd166886;
			13: a = 32'd83443;
			14: a = 32'd41722;
			15: a = 32'd20861;
			16: a = 32'd10430;
			17: a = 32'd5215;
			18: a = 32'd2608;
			19: a = 32'd1304;
			20: a = 32'd652;
			21: a = 32'd326;
			22: a = 32'd163;
			23: a = 32'd81;
			default: a = 32'd0;
		endcase
		return a;
	endfunction

	// Count as used: zero acts as one, large values cap at the maximum
	function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] c);
		logic [CNT_W-1:0] r;
		if (c == '0)
			r = CNT_W'(1);
		else if (c > CNT_W'(MAX_DIVISIONS))
			r = CNT_W'(MAX_DIVISIONS);
		else
			r = c;
		return r;
	endfunction

	// Radius times Q1.30 value, rounded to Q8.8 and saturated
	function automatic logic [16:0] sat_pos(input logic signed [49:0] v);
		logic signed [49:0] r;
		logic [16:0] o;
		r = (v + 50'sd536870912) >>> 30;
		if (r > 50'sd65535)
			o = 17'd65535;
		else if (r < -50'sd65535)
			o = 17'h10001;
		else
			o = r[16:0];
		return o;
	endfunction

	// Q1.30 value rounded to Q1.14 and saturated
	function automatic logic [15:0] sat_nrm(input logic signed [32:0] v);
		logic signed [32:0] r;
		logic [15:0] o;
		r = (v + 33'sd32768) >>> 16;
		if (r > 33'sd16384)
			o = 16'd16384;
		else if (r < -33'sd16384)
			o = 16'hC000;
		else
			o = r[15:0];
		return o;
	endfunction

	typedef struct packed {
		logic [15:0]      radius;
		logic [CNT_W-1:0] sectors;
		logic [CNT_W-1:0] stacks;
	} cfg_t;

	typedef struct packed {
		logic [CNT_W-1:0] stack;
		logic [CNT_W-1:0] sector;
		logic             clamped;
	} item_t;

	typedef struct packed {
		logic        clamped;
		logic [16:0] tex_u;
		logic [16:0] tex_v;
	} meta_t;

	typedef struct packed {
		logic [16:0] pos_x;
		logic [16:0] pos_y;
		logic [16:0] pos_z;
		logic [15:0] normal_x;
		logic [15:0] normal_y;
		logic [15:0] normal_z;
		logic [16:0] tex_u;
		logic [16:0] tex_v;
		logic        index_clamped;
	} result_t;

endpackage

// ----- sv/uv_sphere_vertex_generator.sv -----
`timescale 1ns / 1ps
// UV sphere vertex generator. Push a (stack, sector) grid index, pop one vertex:
// position (radius times normal, Q8.8), unit normal (Q1.14) and texture u, v
// (Q1.16, 65536 = 1.0); an index above its count is clamped and flagged. Items
// are taken one per clock while the input queue is not full, and results come
// out in order after passing through the back end: a 9-stage pipelined divider,
// a 14-stage pipelined CORDIC and 4 stages of multiply, round and saturate. A
// 4-entry input queue and a 2-entry result queue let either side stall; a
// stalled result freezes the whole back end. Registers (APB, words at 0x0, 0x4,
// 0x8): sphere_radius, sector_count, stack_count; a count of 0 acts as 1, above
// 1024 as 1024. Write them only while no item is in flight.
module uv_sphere_vertex_generator import uvs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic [CNT_W-1:0]   stack_index,
	input  logic [CNT_W-1:0]   sector_index,
	input  logic               push,
	output logic               full,
	output logic signed [16:0] pos_x,
	output logic signed [16:0] pos_y,
	output logic signed [16:0] pos_z,
	output logic signed [15:0] normal_x,
	output logic signed [15:0] normal_y,
	output logic signed [15:0] normal_z,
	output logic [16:0]        tex_u,
	output logic [16:0]        tex_v,
	output logic               index_clamped,
	output logic               empty,
	input  logic               pop
);

	logic [15:0]      radius_q;
	logic [CNT_W-1:0] sectors_q, stacks_q;
	logic             wr;
	cfg_t             cfg;
	logic             q_full, q_wr, q_rd, q_vld;
	item_t            wr_item, rd_item;
	result_t          res;

	// Configuration registers
	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q  <= 16'd256;
			sectors_q <= CNT_W'(16);
			stacks_q  <= CNT_W'(16);
		end else if (wr) begin
			case (paddr[3:2])
				REG_RADIUS:  radius_q  <= pwdata[15:0];
				REG_SECTORS: sectors_q <= pwdata[CNT_W-1:0];
				REG_STACKS:  stacks_q  <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_RADIUS:  prdata = {16'b0, radius_q};
			REG_SECTORS: prdata = {{(32-CNT_W){1'b0}}, sectors_q};
			REG_STACKS:  prdata = {{(32-CNT_W){1'b0}}, stacks_q};
			default:     prdata = '0;
		endcase
	end

	// Counts as the datapath uses them
	assign cfg.radius  = radius_q;
	assign cfg.sectors = eff_count(sectors_q);
	assign cfg.stacks  = eff_count(stacks_q);

	uvs_front u_front (
		.cfg          (cfg),
		.stack_index  (stack_index),
		.sector_index (sector_index),
		.push         (push),
		.full         (full),
		.q_full       (q_full),
		.q_wr         (q_wr),
		.q_item       (wr_item)
	);

	uvs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (q_wr),
		.wr_item  (wr_item),
		.full     (q_full),
		.rd       (q_rd),
		.rd_item  (rd_item),
		.nonempty (q_vld)
	);

	uvs_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.q_vld  (q_vld),
		.q_item (rd_item),
		.q_rd   (q_rd),
		.res    (res),
		.empty  (empty),
		.pop    (pop)
	);

	assign pos_x         = res.pos_x;
	assign pos_y         = res.pos_y;
	assign pos_z         = res.pos_z;
	assign normal_x      = res.normal_x;
	assign normal_y      = res.normal_y;
	assign normal_z      = res.normal_z;
	assign tex_u         = res.tex_u;
	assign tex_v         = res.tex_v;
	assign index_clamped = res.index_clamped;

endmodule

// ----- sv/uvs_front.sv -----
`timescale 1ns / 1ps
module uvs_front import uvs_pkg::*; (
	input  cfg_t             cfg,
	input  logic [CNT_W-1:0] stack_index,
	input  logic [CNT_W-1:0] sector_index,
	input  logic             push,
	output logic             full,
	input  logic             q_full,
	output logic             q_wr,
	output item_t            q_item
);

	logic st_over, se_over;

	// Clamp each index to its count and flag it
	always_comb begin
		st_over = stack_index > cfg.stacks;
		se_over = sector_index > cfg.sectors;
		q_item.stack   = st_over ? cfg.stacks : stack_index;
		q_item.sector  = se_over ? cfg.sectors : sector_index;
		q_item.clamped = st_over | se_over;
	end

	assign full = q_full;
	assign q_wr = push & ~q_full;

endmodule

// ----- sv/uvs_queue.sv -----
`timescale 1ns / 1ps
module uvs_queue import uvs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr,
	input  item_t wr_item,
	output logic  full,
	input  logic  rd,
	output item_t rd_item,
	output logic  nonempty
);

	item_t      mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;

	assign full     = cnt_q == 3'd4;
	assign nonempty = cnt_q != 3'd0;
	assign rd_item  = mem_q[rp_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wp_q] <= wr_item;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr)
				wp_q <= wp_q + 2'd1;
			if (rd)
				rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + {2'b0, wr} - {2'b0, rd};
		end
	end

endmodule

// ----- sv/uvs_div.sv -----
`timescale 1ns / 1ps
module uvs_div import uvs_pkg::*; (
	input  logic                clk,
	input  logic                en,
	input  logic [CNT_W-1:0]    num,
	input  logic [CNT_W-1:0]    den,
	output logic [DIV_FRAC:0]   quo,
	output logic [CNT_W-1:0]    rem
);

	// num * 2^32 / den, num <= den; restoring, four quotient bits per stage
	logic [CNT_W-1:0]  rem_s [DIV_STAGES+1];
	logic [DIV_FRAC:0] quo_s [DIV_STAGES+1];
	logic              q0;

	assign q0 = num >= den;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= q0 ? num - den : num;
			quo_s[0] <= {{DIV_FRAC{1'b0}}, q0};
		end
	end

	for (genvar g = 1; g <= DIV_STAGES; g++) begin : g_stage
		logic [CNT_W-1:0]  r_c;
		logic [DIV_FRAC:0] q_c;
		logic [CNT_W:0]    r2;
		logic              ge;

		always_comb begin
			r_c = rem_s[g-1];
			q_c = quo_s[g-1];
			r2  = '0;
			ge  = 1'b0;
			for (int j = 0; j < DIV_BITS; j++) begin
				r2  = {r_c, 1'b0};
				ge  = r2 >= {1'b0, den};
				r_c = ge ? CNT_W'(r2 - {1'b0, den}) : CNT_W'(r2);
				q_c = {q_c[DIV_FRAC-1:0], ge};
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g] <= r_c;
				quo_s[g] <= q_c;
			end
		end
	end

	assign quo = quo_s[DIV_STAGES];
	assign rem = rem_s[DIV_STAGES];

endmodule

// ----- sv/uvs_cordic.sv -----
`timescale 1ns / 1ps
module uvs_cordic import uvs_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic [31:0]        phase,
	output logic signed [32:0] cos_q,
	output logic signed [32:0] sin_q
);

	logic signed [32:0] x_s [CORDIC_STAGES+1];
	logic signed [32:0] y_s [CORDIC_STAGES+1];
	logic signed [32:0] z_s [CORDIC_STAGES+1];
	logic               f_s [CORDIC_STAGES+1];
	logic [31:0]        turn;
	logic [31:0]        p;
	logic               flip;

	// Fold the second and third quarter turns by a half turn
	always_comb begin
		turn = phase + 32'h4000_0000;
		flip = turn[31];
		p    = flip ? phase - 32'h8000_0000 : phase;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= CORDIC_ONE;
			y_s[0] <= '0;
			z_s[0] <= {p[31], p};
			f_s[0] <= flip;
		end
	end

	// Rotation steps, two per stage
	for (genvar g = 1; g <= CORDIC_STAGES; g++) begin : g_stage
		logic signed [32:0] xa, ya, za, dx, dy, at;

		always_comb begin
			xa = x_s[g-1];
			ya = y_s[g-1];
			za = z_s[g-1];
			dx = '0;
			dy = '0;
			at = '0;
			for (int j = 0; j < CORDIC_PER_STAGE; j++) begin
				dx = ya >>> ((g - 1) * CORDIC_PER_STAGE + j);
				dy = xa >>> ((g - 1) * CORDIC_PER_STAGE + j);
				at = $signed({1'b0, atan_turn((g - 1) * CORDIC_PER_STAGE + j)});
				if (!za[32]) begin
					xa = xa - dx;
					ya = ya + dy;
					za = za - at;
				end else begin
					xa = xa + dx;
					ya = ya - dy;
					za = za + at;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[g] <= xa;
				y_s[g] <= ya;
				z_s[g] <= za;
				f_s[g] <= f_s[g-1];
			end
		end
	end

	// Undo the fold
	always_ff @(posedge clk) begin
		if (en) begin
			cos_q <= f_s[CORDIC_STAGES] ? -x_s[CORDIC_STAGES] : x_s[CORDIC_STAGES];
			sin_q <= f_s[CORDIC_STAGES] ? -y_s[CORDIC_STAGES] : y_s[CORDIC_STAGES];
		end
	end

endmodule

// ----- sv/uvs_back.sv -----
`timescale 1ns / 1ps
module uvs_back import uvs_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    q_vld,
	input  item_t   q_item,
	output logic    q_rd,
	output result_t res,
	output logic    empty,
	input  logic    pop
);

	logic en;
	logic rq_full;

	// Divider segment bookkeeping
	logic a_vld_q [DIV_LAT];
	logic a_clm_s [DIV_LAT];

	logic [DIV_FRAC:0] lon_quo, lat_quo;
	logic [CNT_W-1:0]  lon_rem, lat_rem;
	logic [31:0]       lon_p, lat_p;
	logic [DIV_FRAC+1:0] lat_inc;
	logic [16:0]       tu, tv;
	logic              lon_up;

	// CORDIC segment bookkeeping
	meta_t b_s [COR_LAT];
	logic  b_vld_q [COR_LAT];
	logic signed [32:0] clat, slat, clon, slon;

	// Product stages
	logic               vld_s1, vld_s2, vld_s3, vld_s4;
	meta_t              m_s1, m_s2, m_s3;
	logic signed [63:0] px_s1, pz_s1;
	logic signed [32:0] ny_s1;
	logic signed [32:0] nx_s2, ny_s2, nz_s2;
	logic signed [49:0] rx_s3, ry_s3, rz_s3;
	logic [15:0]        nrx_s3, nry_s3, nrz_s3;
	result_t            r_s4;

	// Result queue
	result_t    rq_q [2];
	logic       rq_wp_q, rq_rp_q;
	logic [1:0] rq_cnt_q;

	// Whole pipeline stalls only when the last stage cannot leave
	assign en   = ~(vld_s4 & rq_full);
	assign q_rd = en & q_vld;

	uvs_div u_div_lon (
		.clk (clk),
		.en  (en),
		.num (q_item.sector),
		.den (cfg.sectors),
		.quo (lon_quo),
		.rem (lon_rem)
	);

	uvs_div u_div_lat (
		.clk (clk),
		.en  (en),
		.num (q_item.stack),
		.den (cfg.stacks),
		.quo (lat_quo),
		.rem (lat_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_LAT; i++)
				a_vld_q[i] <= 1'b0;
		end else if (en) begin
			a_vld_q[0] <= q_vld;
			for (int i = 1; i < DIV_LAT; i++)
				a_vld_q[i] <= a_vld_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_clm_s[0] <= q_item.clamped;
			for (int i = 1; i < DIV_LAT; i++)
				a_clm_s[i] <= a_clm_s[i-1];
		end
	end

	// Angles and texture coordinates from the exact quotients
	always_comb begin
		lon_up  = {lon_rem, 1'b0} >= {1'b0, cfg.sectors};
		lon_p   = lon_quo[31:0] + {31'b0, lon_up};
		tu      = lon_quo[32:16] + {16'b0, lon_quo[15]};
		lat_inc = {1'b0, lat_quo} + 34'd1;
		lat_p   = 32'h4000_0000 - lat_inc[32:1];
		tv      = lat_quo[32:16] + {16'b0, lat_quo[15]};
	end

	uvs_cordic u_cor_lat (
		.clk   (clk),
		.en    (en),
		.phase (lat_p),
		.cos_q (clat),
		.sin_q (slat)
	);

	uvs_cordic u_cor_lon (
		.clk   (clk),
		.en    (en),
		.phase (lon_p),
		.cos_q (clon),
		.sin_q (slon)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < COR_LAT; i++)
				b_vld_q[i] <= 1'b0;
		end else if (en) begin
			b_vld_q[0] <= a_vld_q[DIV_LAT-1];
			for (int i = 1; i < COR_LAT; i++)
				b_vld_q[i] <= b_vld_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			b_s[0].clamped <= a_clm_s[DIV_LAT-1];
			b_s[0].tex_u   <= tu;
			b_s[0].tex_v   <= tv;
			for (int i = 1; i < COR_LAT; i++)
				b_s[i] <= b_s[i-1];
		end
	end

	// Valid bits of the product stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= b_vld_q[COR_LAT-1];
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// Normal products, rounding, radius scaling, saturation
	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= $signed(clat[31:0]) * $signed(clon[31:0]);
			pz_s1 <= $signed(clat[31:0]) * $signed(slon[31:0]);
			ny_s1 <= slat;
			m_s1  <= b_s[COR_LAT-1];

			nx_s2 <= 33'((px_s1 + 64'sd536870912) >>> 30);
			nz_s2 <= 33'((pz_s1 + 64'sd536870912) >>> 30);
			ny_s2 <= ny_s1;
			m_s2  <= m_s1;

			rx_s3  <= $signed({1'b0, cfg.radius}) * nx_s2;
			ry_s3  <= $signed({1'b0, cfg.radius}) * ny_s2;
			rz_s3  <= $signed({1'b0, cfg.radius}) * nz_s2;
			nrx_s3 <= sat_nrm(nx_s2);
			nry_s3 <= sat_nrm(ny_s2);
			nrz_s3 <= sat_nrm(nz_s2);
			m_s3   <= m_s2;

			r_s4.pos_x         <= sat_pos(rx_s3);
			r_s4.pos_y         <= sat_pos(ry_s3);
			r_s4.pos_z         <= sat_pos(rz_s3);
			r_s4.normal_x      <= nrx_s3;
			r_s4.normal_y      <= nry_s3;
			r_s4.normal_z      <= nrz_s3;
			r_s4.tex_u         <= m_s3.tex_u;
			r_s4.tex_v         <= m_s3.tex_v;
			r_s4.index_clamped <= m_s3.clamped;
		end
	end

	// Two-entry result queue decouples the pipeline from the consumer
	assign rq_full = rq_cnt_q == 2'd2;
	assign empty   = rq_cnt_q == 2'd0;
	assign res     = rq_q[rq_rp_q];

	always_ff @(posedge clk) begin
		if (vld_s4 & ~rq_full)
			rq_q[rq_wp_q] <= r_s4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_wp_q  <= 1'b0;
			rq_rp_q  <= 1'b0;
			rq_cnt_q <= '0;
		end else begin
			if (vld_s4 & ~rq_full)
				rq_wp_q <= ~rq_wp_q;
			if (pop & ~empty)
				rq_rp_q <= ~rq_rp_q;
			rq_cnt_q <= rq_cnt_q + {1'b0, vld_s4 & ~rq_full} - {1'b0, pop & ~empty};
		end
	end

endmodule

// ----- sv/uvs_checker.sv -----
`timescale 1ns / 1ps
module uvs_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               push,
	input logic               full,
	input logic               pop,
	input logic               empty,
	input logic signed [16:0] pos_x,
	input logic signed [16:0] pos_y,
	input logic signed [16:0] pos_z,
	input logic signed [15:0] normal_x,
	input logic signed [15:0] normal_y,
	input logic signed [15:0] normal_z,
	input logic [16:0]        tex_u,
	input logic [16:0]        tex_v
);

	// Items taken in but not yet delivered
	logic [7:0] pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pend_q <= '0;
		else
			pend_q <= pend_q + {7'b0, push & ~full} - {7'b0, pop & ~empty};
	end

	// No result without an item behind it
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> pend_q != 8'd0)
		else $error("result shown with no item pending");

	// A waiting result stays put, as seen on pos_x, normal_y and tex_u
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(pos_x) && $stable(normal_y) && $stable(tex_u))
		else $error("waiting result changed");

	// Normals saturate to one
	a_nrm: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> normal_x <= 16'sd16384 && normal_x >= -16'sd16384 &&
			normal_y <= 16'sd16384 && normal_y >= -16'sd16384 &&
			normal_z <= 16'sd16384 && normal_z >= -16'sd16384)
		else $error("normal out of range");

	// Positions and texture coordinates stay in range
	a_pos: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> pos_x != 17'sh10000 && pos_y != 17'sh10000 && pos_z != 17'sh10000 &&
			tex_u <= 17'd65536 && tex_v <= 17'd65536)
		else $error("position or texture out of range");

endmodule

bind uv_sphere_vertex_generator uvs_checker u_chk (.*);

// ----- sim/uv_sphere_vertex_checker.sv -----
`timescale 1ns / 1ps
// Watches the push and pop sides, predicts each vertex and compares in order.
module uv_sphere_vertex_checker import uvs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [31:0]        pwdata,
	input  logic [CNT_W-1:0]   stack_index,
	input  logic [CNT_W-1:0]   sector_index,
	input  logic               push,
	input  logic               full,
	input  logic signed [16:0] pos_x,
	input  logic signed [16:0] pos_y,
	input  logic signed [16:0] pos_z,
	input  logic signed [15:0] normal_x,
	input  logic signed [15:0] normal_y,
	input  logic signed [15:0] normal_z,
	input  logic [16:0]        tex_u,
	input  logic [16:0]        tex_v,
	input  logic               index_clamped,
	input  logic               empty,
	input  logic               pop,
	output int                 fail_count,
	output int                 pending
);

	localparam longint CORDIC_UNIT = 64'sd652032874;

	// Shadow registers
	logic [15:0]      radius_q;
	logic [CNT_W-1:0] sectors_q;
	logic [CNT_W-1:0] stacks_q;

	result_t vertex_q[$];

	assign pending = vertex_q.size();

	function automatic longint flr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint rnd(longint v, int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic longint clip(longint v, longint lim);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	function automatic longint used_count(logic [CNT_W-1:0] c);
		if (c == 0)
			return 1;
		if (c > MAX_DIVISIONS)
			return MAX_DIVISIONS;
		return c;
	endfunction

	// Arctangent table, fractions of a full turn
	function automatic longint arc_step(int i);
		longint t[24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
			21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772,
			166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326,
			163, 81};
		return t[i];
	endfunction

	// Cosine and sine of a turn fraction, Q1.30
	function automatic void turn_rotate(input logic [31:0] phase, output longint c,
			output longint s);
		logic        flip;
		logic [31:0] p, t;
		longint      x, y, z, dx, dy;
		t = phase + 32'h4000_0000;
		flip = t[31];
		p = flip ? phase - 32'h8000_0000 : phase;
		z = longint'($signed(p));
		x = CORDIC_UNIT;
		y = 0;
		for (int i = 0; i < 24; i++) begin
			dx = flr(y, i);
			dy = flr(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= arc_step(i);
			end else begin
				x += dx; y -= dy; z += arc_step(i);
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic result_t vertex_of(logic [CNT_W-1:0] st_in,
			logic [CNT_W-1:0] se_in);
		result_t r;
		longint stk, sec, st, se, clat, slat, clon, slon, nx, ny, nz, rad;
		logic [63:0] lon_w, half_lat;
		logic [31:0] lat_p;
		stk = used_count(stacks_q);
		sec = used_count(sectors_q);
		st = st_in;
		se = se_in;
		r.index_clamped = 1'b0;
		if (st > stk) begin
			st = stk; r.index_clamped = 1'b1;
		end
		if (se > sec) begin
			se = sec; r.index_clamped = 1'b1;
		end
		r.tex_u = 17'((se * 131072 + sec) / (2 * sec));
		r.tex_v = 17'((st * 131072 + stk) / (2 * stk));
		lon_w = (se * (64'd1 << 33) + sec) / (2 * sec);
		half_lat = (st * (64'd1 << 32) + stk) / (2 * stk);
		lat_p = 32'h4000_0000 - half_lat[31:0];
		turn_rotate(lat_p, clat, slat);
		turn_rotate(lon_w[31:0], clon, slon);
		nx = rnd(clat * clon, 30);
		ny = slat;
		nz = rnd(clat * slon, 30);
		rad = radius_q;
		r.pos_x = 17'(clip(rnd(rad * nx, 30), 65535));
		r.pos_y = 17'(clip(rnd(rad * ny, 30), 65535));
		r.pos_z = 17'(clip(rnd(rad * nz, 30), 65535));
		r.normal_x = 16'(clip(rnd(nx, 16), 16384));
		r.normal_y = 16'(clip(rnd(ny, 16), 16384));
		r.normal_z = 16'(clip(rnd(nz, 16), 16384));
		return r;
	endfunction

	task automatic field_check(string name, longint exp_v, longint got_v);
		if (exp_v != got_v) begin
			$display("%0t: %s mismatch, expected %0d got %0d", $time, name, exp_v,
				got_v);
			fail_count++;
		end
	endtask

	// Register writes, accepted items and popped results
	always @(posedge clk or negedge arst_n) begin
		result_t e;
		if (!arst_n) begin
			radius_q   <= 16'd256;
			sectors_q  <= 11'd16;
			stacks_q   <= 11'd16;
			fail_count = 0;
			vertex_q.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_RADIUS:  radius_q  <= pwdata[15:0];
					REG_SECTORS: sectors_q <= pwdata[CNT_W-1:0];
					REG_STACKS:  stacks_q  <= pwdata[CNT_W-1:0];
					default: ;
				endcase
			end
			if (push && !full)
				vertex_q.insert(vertex_q.size(), vertex_of(stack_index, sector_index));
			if (pop && !empty) begin
				if (vertex_q.size() == 0) begin
					$display("%0t: result popped with none expected", $time);
					fail_count++;
				end else begin
					e = vertex_q.pop_front();
					field_check("pos_x", $signed(e.pos_x), pos_x);
					field_check("pos_y", $signed(e.pos_y), pos_y);
					field_check("pos_z", $signed(e.pos_z), pos_z);
					field_check("normal_x", $signed(e.normal_x), normal_x);
					field_check("normal_y", $signed(e.normal_y), normal_y);
					field_check("normal_z", $signed(e.normal_z), normal_z);
					field_check("tex_u", e.tex_u, tex_u);
					field_check("tex_v", e.tex_v, tex_v);
					field_check("index_clamped", e.index_clamped, index_clamped);
				end
			end
		end
	end

endmodule

// ----- sim/uv_sphere_vertex_generator_test.sv -----
`timescale 1ns / 1ps
module uv_sphere_vertex_generator_test;
	import uvs_pkg::*;

	localparam longint CYCLE_LIMIT = 400000;

	logic clk, arst_n;
	logic psel, penable, pwrite, pready;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata, prdata;
	logic [CNT_W-1:0] stack_index, sector_index;
	logic push, full, empty, pop;
	logic signed [16:0] pos_x, pos_y, pos_z;
	logic signed [15:0] normal_x, normal_y, normal_z;
	logic [16:0] tex_u, tex_v;
	logic index_clamped;
	int fail_count, pending;
	longint cycles;
	logic [CNT_W-1:0] cur_stacks, cur_sectors;

	uv_sphere_vertex_generator u_dut (.*);
	uv_sphere_vertex_checker u_chk (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("uv_sphere_vertex_generator verification failed");
				$finish;
			end
		end
	end

	// Gap length: mostly short, sometimes long
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Result side: random pop stalls, with calm stretches
	initial begin
		int g;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if ((cycles / 2000) % 4 == 3) begin
				pop <= 1'b1;
			end else begin
				g = gap_len();
				if (g == 0) begin
					pop <= 1'b1;
				end else begin
					pop <= 1'b0;
					repeat (g - 1) @(negedge clk);
				end
			end
		end
	end

	task automatic reg_write(logic [1:0] idx, logic [31:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({idx, 2'b00});
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == REG_SECTORS)
			cur_sectors = val[CNT_W-1:0];
		if (idx == REG_STACKS)
			cur_stacks = val[CNT_W-1:0];
	endtask

	// One item; push held high across back-to-back items
	task automatic send_item(logic [CNT_W-1:0] st, logic [CNT_W-1:0] se, bit burst);
		int g;
		g = burst ? 0 : gap_len();
		if (g > 0) begin
			push <= 1'b0;
			repeat (g) @(negedge clk);
		end
		push         <= 1'b1;
		stack_index  <= st;
		sector_index <= se;
		@(posedge clk);
		while (full)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		push <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [CNT_W-1:0] pick_index(logic [CNT_W-1:0] cnt);
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return CNT_W'($urandom_range(0, 2047));
		if (r < 14)
			return cnt;
		if (cnt > 1024)
			return CNT_W'($urandom_range(0, 1024));
		return CNT_W'($urandom_range(0, cnt));
	endfunction

	initial begin
		logic [31:0] rad_set[6] = '{32'd256, 32'd0, 32'd65535, 32'd1, 32'd12345, 32'd512};
		logic [31:0] sec_set[6] = '{32'd1, 32'd0, 32'd1024, 32'd2047, 32'd7, 32'd3};
		logic [31:0] stk_set[6] = '{32'd1024, 32'd1, 32'd0, 32'd2047, 32'd5, 32'd33};
		logic [31:0] r32;
		bit burst;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		push = 0; stack_index = '0; sector_index = '0;
		cur_stacks = 11'd16; cur_sectors = 11'd16;
		arst_n = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: reset setting, poles, equator, full turn, clamping, extremes
		send_item(11'd0, 11'd0, 1'b0);
		send_item(11'd16, 11'd16, 1'b0);
		send_item(11'd8, 11'd4, 1'b1);
		send_item(11'd8, 11'd12, 1'b1);
		send_item(11'd4, 11'd2, 1'b1);
		send_item(11'd17, 11'd3, 1'b0);
		send_item(11'd3, 11'd17, 1'b0);
		send_item(11'h7FF, 11'h7FF, 1'b0);
		send_item(11'h555, 11'h2AA, 1'b1);
		send_item(11'h2AA, 11'h555, 1'b1);
		send_item(11'd12, 11'd8, 1'b0);
		send_item(11'd16, 11'd0, 1'b0);
		drain();
		reg_write(REG_RADIUS, 32'd65535);
		reg_write(REG_SECTORS, 32'd1024);
		reg_write(REG_STACKS, 32'd0);
		send_item(11'd0, 11'd1024, 1'b0);
		send_item(11'd1, 11'd512, 1'b0);
		send_item(11'd0, 11'd256, 1'b1);
		send_item(11'd1, 11'd1023, 1'b1);
		send_item(11'd2, 11'd2047, 1'b0);
		drain();

		// Random phases over several settings
		for (int ph = 0; ph < 8; ph++) begin
			r32 = ph < 6 ? rad_set[ph] : $urandom_range(0, 65535);
			reg_write(REG_RADIUS, r32);
			reg_write(REG_SECTORS, ph < 6 ? sec_set[ph] : $urandom_range(0, 2047));
			reg_write(REG_STACKS, ph < 6 ? stk_set[ph] : $urandom_range(0, 2047));
			for (int n = 0; n < 137; n++) begin
				burst = ($urandom_range(0, 3) != 0) && (n % 40 < 20);
				send_item(pick_index(cur_stacks), pick_index(cur_sectors), burst);
			end
			drain();
		end

		if (fail_count == 0)
			$display("uv_sphere_vertex_generator verification clean");
		else
			$display("uv_sphere_vertex_generator verification failed");
		$finish;
	end

endmodule
